// ===== rtl/keyboard_scancode_translator_defines.svh =====
// Assertion macros for the keyboard scancode translator.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef KEYBOARD_SCANCODE_TRANSLATOR_DEFINES_SVH
`define KEYBOARD_SCANCODE_TRANSLATOR_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define KST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kst: same-cycle check failed");
// next-cycle implication
`define KST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kst: next-cycle check failed");
`else
`define KST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/kst_pkg.sv =====
// Shared types, scan codes, result kinds and layout tables of the scancode translator.
// No dependencies.
package kst_pkg;

	typedef logic [2:0] kind_t;

	// result kinds
	localparam kind_t KIND_CHAR   = 3'd0;
	localparam kind_t KIND_BKSP   = 3'd1;
	localparam kind_t KIND_ENTER  = 3'd2;
	localparam kind_t KIND_FOCUS  = 3'd3;
	localparam kind_t KIND_KBBYTE = 3'd4;

	// set-1 scan codes of interest
	localparam logic [7:0] SC_BACKSPACE    = 8'h0e;
	localparam logic [7:0] SC_TAB          = 8'h0f;
	localparam logic [7:0] SC_ENTER        = 8'h1c;
	localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2a;
	localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BREAK = 8'haa;
	localparam logic [7:0] SC_RSHIFT_BREAK = 8'hb6;
	localparam logic [7:0] SC_CAPS_LOCK    = 8'h3a;
	localparam logic [7:0] SC_NUM_LOCK     = 8'h45;
	localparam logic [7:0] SC_SCROLL_LOCK  = 8'h46;
	localparam logic [7:0] SC_ACK          = 8'hfa;
	localparam logic [7:0] SC_RESEND       = 8'hfe;

	// keyboard command and ASCII constants
	localparam logic [7:0] KB_CMD_SET_LEDS = 8'hed;
	localparam logic [7:0] ASCII_BS        = 8'h08;
	localparam logic [7:0] ASCII_LF        = 8'h0a;
	localparam logic [7:0] ASCII_UPPER_A   = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z   = 8'h5a;
	localparam logic [7:0] CASE_OFFSET     = 8'h20;

	// lock LED bits
	localparam logic [2:0] LED_SCROLL = 3'b001;
	localparam logic [2:0] LED_NUM    = 3'b010;
	localparam logic [2:0] LED_CAPS   = 3'b100;

	// decoded request handed from the front to the command unit
	typedef struct packed {
		logic       ev_valid;
		kind_t      ev_kind;
		logic [7:0] ev_value;
		logic       ev_target;
		logic       push;
		logic [2:0] leds;
		logic       ack;
		logic       resend;
	} op_t;

	// unshifted layout
	function automatic logic [7:0] layout_plain(input logic [6:0] c);
		logic [7:0] r;
		unique case (c)
			7'h02: r = 8'h31;
			7'h03: r = 8'h32;
			7'h04: r = 8'h33;
			7'h05: r = 8'h34;
			7'h06: r = 8'h35;
			7'h07: r = 8'h36;
			7'h08: r = 8'h37;
			7'h09: r = 8'h38;
			7'h0a: r = 8'h39;
			7'h0b: r = 8'h30;
			7'h0c: r = 8'h2d;
			7'h0d: r = 8'h5e;
			7'h10: r = 8'h51;
			7'h11: r = 8'h57;
			7'h12: r = 8'h45;
			7'h13: r = 8'h52;
			7'h14: r = 8'h54;
			7'h15: r = 8'h59;
			7'h16: r = 8'h55;
			7'h17: r = 8'h49;
			7'h18: r = 8'h4f;
			7'h19: r = 8'h50;
			7'h1a: r = 8'h40;
			7'h1b: r = 8'h5b;
			7'h1e: r = 8'h41;
			7'h1f: r = 8'h53;
			7'h20: r = 8'h44;
			7'h21: r = 8'h46;
			7'h22: r = 8'h47;
			7'h23: r = 8'h48;
			7'h24: r = 8'h4a;
			7'h25: r = 8'h4b;
			7'h26: r = 8'h4c;
			7'h27: r = 8'h3b;
			7'h28: r = 8'h3a;
			7'h2b: r = 8'h5d;
			7'h2c: r = 8'h5a;
			7'h2d: r = 8'h58;
			7'h2e: r = 8'h43;
			7'h2f: r = 8'h56;
			7'h30: r = 8'h42;
			7'h31: r = 8'h4e;
			7'h32: r = 8'h4d;
			7'h33: r = 8'h2c;
			7'h34: r = 8'h2e;
			7'h35: r = 8'h2f;
			7'h37: r = 8'h2a;
			7'h39: r = 8'h20;
			7'h47: r = 8'h37;
			7'h48: r = 8'h38;
			7'h49: r = 8'h39;
			7'h4a: r = 8'h2d;
			7'h4b: r = 8'h34;
			7'h4c: r = 8'h35;
			7'h4d: r = 8'h36;
			7'h4e: r = 8'h2b;
			7'h4f: r = 8'h31;
			7'h50: r = 8'h32;
			7'h51: r = 8'h33;
			7'h52: r = 8'h30;
			7'h53: r = 8'h2e;
			7'h73: r = 8'h5c;
			7'h7d: r = 8'h5c;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// shifted layout: only the keys that differ from the plain layout
	function automatic logic [7:0] layout_shifted(input logic [6:0] c);
		logic [7:0] r;
		unique case (c)
			7'h02: r = 8'h21;
			7'h03: r = 8'h22;
			7'h04: r = 8'h23;
			7'h05: r = 8'h24;
			7'h06: r = 8'h25;
			7'h07: r = 8'h26;
			7'h08: r = 8'h27;
			7'h09: r = 8'h28;
			7'h0a: r = 8'h29;
			7'h0b: r = 8'h7e;
			7'h0c: r = 8'h3d;
			7'h0d: r = 8'h7e;
			7'h1a: r = 8'h60;
			7'h1b: r = 8'h7b;
			7'h27: r = 8'h2b;
			7'h28: r = 8'h2a;
			7'h2b: r = 8'h7d;
			7'h33: r = 8'h3c;
			7'h34: r = 8'h3e;
			7'h35: r = 8'h3f;
			7'h73: r = 8'h5f;
			7'h7d: r = 8'h7c;
			default: r = layout_plain(c);
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/kst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/kst_front.sv =====
// Front of the scancode translator: accepts raw bytes, tracks shift, lock LEDs and
// focus, and turns each byte into a decoded request. Depends on kst_pkg.
module kst_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_wdata,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [7:0]     s_tdata,
	input  logic           q_full,
	output logic           q_push,
	output kst_pkg::op_t   q_op
);

	logic [1:0] shift_q;
	logic [2:0] leds_q;
	logic       focus_q;

	logic [7:0] base_ch;
	logic [7:0] ch;
	logic       is_letter;
	logic       focus_nxt;
	logic [2:0] led_mask;
	logic [1:0] shift_nxt;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;

	// layout lookup and case fix
	always_comb begin
		if (s_tdata[7]) begin
			base_ch = 8'h00;
		end else if (shift_q != 2'b00) begin
			base_ch = kst_pkg::layout_shifted(s_tdata[6:0]);
		end else begin
			base_ch = kst_pkg::layout_plain(s_tdata[6:0]);
		end
		is_letter = (base_ch >= kst_pkg::ASCII_UPPER_A) && (base_ch <= kst_pkg::ASCII_UPPER_Z);
		if (is_letter && (leds_q[2] == (shift_q != 2'b00))) begin
			ch = base_ch + kst_pkg::CASE_OFFSET;
		end else begin
			ch = base_ch;
		end
	end

	// state updates implied by this byte
	always_comb begin
		focus_nxt = focus_q ^ (s_tdata == kst_pkg::SC_TAB);
		led_mask  = 3'b000;
		if (s_tdata == kst_pkg::SC_CAPS_LOCK) begin
			led_mask = kst_pkg::LED_CAPS;
		end
		if (s_tdata == kst_pkg::SC_NUM_LOCK) begin
			led_mask = kst_pkg::LED_NUM;
		end
		if (s_tdata == kst_pkg::SC_SCROLL_LOCK) begin
			led_mask = kst_pkg::LED_SCROLL;
		end
		shift_nxt = shift_q;
		if (s_tdata == kst_pkg::SC_LSHIFT_MAKE) begin
			shift_nxt[0] = 1'b1;
		end
		if (s_tdata == kst_pkg::SC_RSHIFT_MAKE) begin
			shift_nxt[1] = 1'b1;
		end
		if (s_tdata == kst_pkg::SC_LSHIFT_BREAK) begin
			shift_nxt[0] = 1'b0;
		end
		if (s_tdata == kst_pkg::SC_RSHIFT_BREAK) begin
			shift_nxt[1] = 1'b0;
		end
	end

	// classify the byte into a request
	always_comb begin
		q_op           = '0;
		q_op.ev_target = focus_q;
		priority if (ch != 8'h00) begin
			q_op.ev_valid = 1'b1;
			q_op.ev_kind  = kst_pkg::KIND_CHAR;
			q_op.ev_value = ch;
		end else if (s_tdata == kst_pkg::SC_BACKSPACE) begin
			q_op.ev_valid = 1'b1;
			q_op.ev_kind  = kst_pkg::KIND_BKSP;
			q_op.ev_value = kst_pkg::ASCII_BS;
		end else if ((s_tdata == kst_pkg::SC_ENTER) && focus_q) begin
			q_op.ev_valid  = 1'b1;
			q_op.ev_kind   = kst_pkg::KIND_ENTER;
			q_op.ev_value  = kst_pkg::ASCII_LF;
			q_op.ev_target = 1'b1;
		end else if (s_tdata == kst_pkg::SC_TAB) begin
			q_op.ev_valid  = 1'b1;
			q_op.ev_kind   = kst_pkg::KIND_FOCUS;
			q_op.ev_value  = {7'd0, focus_nxt};
			q_op.ev_target = 1'b1;
		end else begin
			q_op.ev_valid = 1'b0;
		end
		q_op.push   = (led_mask != 3'b000);
		q_op.leds   = leds_q ^ led_mask;
		q_op.ack    = (s_tdata == kst_pkg::SC_ACK);
		q_op.resend = (s_tdata == kst_pkg::SC_RESEND);
	end

	// hold keyboard state, advance on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 2'b00;
			leds_q  <= 3'b000;
			focus_q <= 1'b0;
		end else if (cfg_we) begin
			shift_q <= 2'b00;
			leds_q  <= cfg_wdata;
			focus_q <= 1'b0;
		end else if (q_push) begin
			shift_q <= shift_nxt;
			leds_q  <= leds_q ^ led_mask;
			focus_q <= focus_nxt;
		end
	end

endmodule

// ===== rtl/kst_opq.sv =====
// Two-slot request queue between the front and the command unit.
// Depends on kst_pkg.
module kst_opq (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         clr,
	input  logic         push,
	input  kst_pkg::op_t push_op,
	output logic         full,
	input  logic         pop,
	output logic         head_valid,
	output kst_pkg::op_t head_op
);

	localparam int SLOTS = 2;

	kst_pkg::op_t                 slot_q [SLOTS];
	logic [$clog2(SLOTS)-1:0]     wr_q;
	logic [$clog2(SLOTS)-1:0]     rd_q;
	logic [$clog2(SLOTS+1)-1:0]   cnt_q;

	assign full       = (cnt_q == ($clog2(SLOTS+1))'(SLOTS));
	assign head_valid = (cnt_q != '0);
	assign head_op    = slot_q[rd_q];

	// store payload
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_op;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else if (clr) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/kst_back.sv =====
// Command unit of the scancode translator: emits events, keeps the keyboard command
// queue, ack wait and resend. Depends on kst_pkg, kst_ram and the defines header.
`include "keyboard_scancode_translator_defines.svh"
module kst_back #(
	parameter int DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_wdata,
	input  logic          op_valid,
	input  kst_pkg::op_t  op,
	output logic          op_pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [15:0]   m_tdata,
	output logic [2:0]    m_tuser,
	output logic          m_tlast
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	localparam logic [1:0] ST_FIRST = 2'd0;
	localparam logic [1:0] ST_PUSH2 = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_SEND  = 2'd3;

	logic [1:0]    st_q, st_d;
	logic          awaiting_q;
	logic [7:0]    outstanding_q;
	logic [PW-1:0] rptr_q, wptr_q;
	logic [CW-1:0] cnt_q;
	logic          init0_q, init1_q;
	logic [2:0]    init_leds_q;

	logic          out_valid_q;
	kst_pkg::kind_t out_kind_q;
	logic [7:0]    out_value_q;
	logic          out_target_q;
	logic          out_last_q;

	logic          out_free;
	logic          room;
	logic          want_pop;
	logic          ram_we;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;
	logic [7:0]    pop_value;
	logic          pop_go;
	logic          ack_clr;
	logic          emit;
	kst_pkg::kind_t e_kind;
	logic [7:0]    e_value;
	logic          e_target;
	logic          e_last;

	kst_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_cmd_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wptr_q),
		.wdata (ram_wdata),
		.raddr (rptr_q),
		.rdata (ram_rdata)
	);

	assign out_free = !out_valid_q || m_tready;
	assign room     = (cnt_q != FULL_CNT);
	assign want_pop = (cnt_q != '0) && !(awaiting_q && !op.ack);

	// the two preloaded entries read from flags until overwritten
	always_comb begin
		if ((rptr_q == '0) && init0_q) begin
			pop_value = kst_pkg::KB_CMD_SET_LEDS;
		end else if ((rptr_q == PW'(1)) && init1_q) begin
			pop_value = {5'd0, init_leds_q};
		end else begin
			pop_value = ram_rdata;
		end
	end

	// sequence one request
	always_comb begin
		st_d      = st_q;
		ram_we    = 1'b0;
		ram_wdata = kst_pkg::KB_CMD_SET_LEDS;
		op_pop    = 1'b0;
		pop_go    = 1'b0;
		ack_clr   = 1'b0;
		emit      = 1'b0;
		e_kind    = op.ev_kind;
		e_value   = op.ev_value;
		e_target  = op.ev_target;
		e_last    = 1'b1;
		unique case (st_q)
			ST_FIRST: begin
				if (op_valid) begin
					ack_clr = op.ack;
					if (op.push) begin
						ram_we = room;
						st_d   = ST_PUSH2;
					end else if (op.ev_valid) begin
						if (out_free) begin
							emit   = 1'b1;
							e_last = !want_pop;
							if (want_pop) begin
								st_d = ST_SEND;
							end else begin
								op_pop = 1'b1;
							end
						end
					end else if (op.resend && awaiting_q) begin
						if (out_free) begin
							emit     = 1'b1;
							e_kind   = kst_pkg::KIND_KBBYTE;
							e_value  = outstanding_q;
							e_target = 1'b0;
							op_pop   = 1'b1;
						end
					end else if (want_pop) begin
						st_d = ST_SEND;
					end else begin
						op_pop = 1'b1;
					end
				end
			end
			ST_PUSH2: begin
				ram_we    = room;
				ram_wdata = {5'd0, op.leds};
				if (((cnt_q != '0) || room) && !awaiting_q) begin
					st_d = ST_READ;
				end else begin
					op_pop = 1'b1;
					st_d   = ST_FIRST;
				end
			end
			ST_READ: begin
				st_d = ST_SEND;
			end
			ST_SEND: begin
				if (out_free) begin
					emit     = 1'b1;
					e_kind   = kst_pkg::KIND_KBBYTE;
					e_value  = pop_value;
					e_target = 1'b0;
					pop_go   = 1'b1;
					op_pop   = 1'b1;
					st_d     = ST_FIRST;
				end
			end
		endcase
	end

	// command queue, ack wait and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_FIRST;
			awaiting_q    <= 1'b0;
			outstanding_q <= 8'h00;
			rptr_q        <= '0;
			wptr_q        <= PW'(2);
			cnt_q         <= CW'(2);
			init0_q       <= 1'b1;
			init1_q       <= 1'b1;
			init_leds_q   <= 3'b000;
		end else if (cfg_we) begin
			st_q          <= ST_FIRST;
			awaiting_q    <= 1'b0;
			outstanding_q <= 8'h00;
			rptr_q        <= '0;
			wptr_q        <= PW'(2);
			cnt_q         <= CW'(2);
			init0_q       <= 1'b1;
			init1_q       <= 1'b1;
			init_leds_q   <= cfg_wdata;
		end else begin
			st_q <= st_d;
			if (ack_clr) begin
				awaiting_q <= 1'b0;
			end
			if (ram_we) begin
				wptr_q <= (wptr_q == LAST_SLOT) ? '0 : wptr_q + 1'b1;
				cnt_q  <= cnt_q + 1'b1;
				if (wptr_q == '0) begin
					init0_q <= 1'b0;
				end
				if (wptr_q == PW'(1)) begin
					init1_q <= 1'b0;
				end
			end
			if (pop_go) begin
				rptr_q        <= (rptr_q == LAST_SLOT) ? '0 : rptr_q + 1'b1;
				cnt_q         <= cnt_q - 1'b1;
				awaiting_q    <= 1'b1;
				outstanding_q <= pop_value;
			end
		end
	end

	// output register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cfg_we) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q   <= e_kind;
			out_value_q  <= e_value;
			out_target_q <= e_target;
			out_last_q   <= e_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_target_q, out_value_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

`KST_ASSERT_IMP(a_empty_ptrs_meet, clk, arst_n, cnt_q == '0, rptr_q == wptr_q)
`KST_ASSERT_IMP(a_send_has_entry, clk, arst_n, st_q == ST_SEND, cnt_q != '0)
`KST_ASSERT_IMP(a_send_not_waiting, clk, arst_n, st_q == ST_SEND, !awaiting_q)
`KST_ASSERT_NEXT(a_send_arms_wait, clk, arst_n, pop_go && !cfg_we, awaiting_q)

endmodule

// ===== rtl/keyboard_scancode_translator.sv =====
// Set-1 keyboard scancode translator. Each raw byte is taken by the front when the queue
// has room; the front tracks shift, lock LEDs and focus and decodes the byte into a
// request held in a two-slot queue. For a lock key the command unit writes 0xED and the
// LED byte into the command RAM and, unless an ack is awaited, reads the RAM and then
// sends a queued byte; the single-write-port RAM and its registered read make these
// separate steps. Other requests emit their event and may also pop a queued command
// byte. Results leave through an output register, so new bytes are accepted while a
// result waits. The two bytes preloaded at reset (0xED, initial LEDs) need no clearing
// pass: they are served from flags until overwritten. Writing cfg_wdata restarts all state.
// Depends on kst_pkg, kst_front, kst_opq and kst_back.
module keyboard_scancode_translator #(
	parameter int CMD_QUEUE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,  // initial_lock_leds
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] scan_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [7:0] value, [8] target, [15:9] zero
	output logic [2:0]  m_tuser,    // [2:0] kind
	output logic        m_tlast     // last
);

	logic         q_full;
	logic         q_push;
	kst_pkg::op_t q_op;
	logic         head_valid;
	kst_pkg::op_t head_op;
	logic         head_pop;

	kst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_op      (q_op)
	);

	kst_opq u_opq (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr        (cfg_we),
		.push       (q_push),
		.push_op    (q_op),
		.full       (q_full),
		.pop        (head_pop),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	kst_back #(
		.DEPTH (CMD_QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op_valid  (head_valid),
		.op        (head_op),
		.op_pop    (head_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
